>>> rtl/core/cff_pkg.sv
// coupon flow filter package: constants and the rotl hash helper function
// no dependencies
`default_nettype none
package cff_pkg;
  localparam int unsigned UNITS_DEF   = 65536;
  localparam int unsigned COUPONS_DEF = 4;
  localparam logic [31:0] SEED_RST    = 32'd1337;
  localparam logic [31:0] STEP_RST    = 32'd429496730;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_LAYOUT = 2'd2;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/cff_if.sv
// valid/ready channel interface with a generic payload
// depends on nothing
`default_nettype none
interface cff_if #(parameter int W = 64) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cff_ram.sv
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module cff_ram #(
  parameter int W = 4,
  parameter int D = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/coupon_flow_filter_core.sv
// coupon flow filter top level: hash pipeline, bitmap memory and clearing pass
// depends on cff_pkg, cff_if, cff_ram
// The block works on one request at a time. The next request is taken in the
// cycle after the result is accepted. An item passes through the hash chain of
// registered multiplier stages (one more hashed word with the 12-byte layout),
// one coupon compare a cycle until a hit or the last coupon, and the bitmap
// read-modify-write. After reset a clearing pass writes zero to every bitmap
// entry, one a cycle, while no request is taken. The in channel data is
// {element_key, flow_key}; out data is {out_element_key, out_flow_key,
// unit_number, coupon_number, coupon_hit, passed}; cfg data is {index, value}.
`default_nettype none
module coupon_flow_filter_core #(
  parameter int UNITS   = cff_pkg::UNITS_DEF,
  parameter int COUPONS = cff_pkg::COUPONS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  cff_if.sink      in_ch,
  cff_if.source    out_ch,
  cff_if.sink      cfg_ch
);
  localparam int AW = $clog2(UNITS);
  localparam int CW = (COUPONS > 1) ? $clog2(COUPONS) : 1;

  typedef enum logic [2:0] {CLR, IDLE, HASH, RD, WB, OUT} st_t;
  st_t st_r;

  logic [31:0] seed_r, step_r;
  logic        layout_r;
  logic [AW:0] clr_r;
  logic [3:0]  ph_r;
  logic [31:0] fk_r, ek_r;
  // unit hash lanes and coupon hash
  logic [31:0] a_r, b_r, c_r, d_r, k_r, h_r;
  logic [1:0]  wi_r;
  logic [AW-1:0] unit_r;
  logic        hit_r;
  logic [CW-1:0] cpn_r;
  logic [COUPONS-1:0] rd;
  logic        we;
  logic [AW-1:0] waddr;
  logic [COUPONS-1:0] wdata, newv;
  logic        passed_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st_r == IDLE);
  assign out_ch.valid = (st_r == OUT);
  assign out_ch.data  = {ek_r, fk_r, 16'(unit_r), 3'(cpn_r), hit_r, passed_r};

  cff_ram #(.W(COUPONS), .D(UNITS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(unit_r), .rdata(rd));

  assign newv = hit_r ? (rd | (COUPONS'(1) << cpn_r)) : rd;
  always_comb begin
    we = 1'b0; waddr = unit_r; wdata = newv;
    if (st_r == CLR) begin
      we = 1'b1; waddr = clr_r[AW-1:0]; wdata = '0;
    end else if (st_r == WB) begin
      we = 1'b1;
    end
  end

  function automatic logic [31:0] fmix_a(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    fmix_a = t * 32'h85ebca6b;
  endfunction
  function automatic logic [31:0] fmix_b(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 13);
    fmix_b = t * 32'hc2b2ae35;
  endfunction

  logic [31:0] wsel;
  logic [2:0]  wcnt;
  always_comb begin
    wcnt = layout_r ? 3'd3 : 3'd2;
    case (wi_r)
      2'd0: wsel = fk_r;
      2'd1: wsel = layout_r ? 32'd0 : ek_r;
      default: wsel = ek_r;
    endcase
  end

  // threshold compare, one coupon at a time in the RD state
  logic [35:0] thr_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CLR; clr_r <= '0;
      seed_r <= cff_pkg::SEED_RST; step_r <= cff_pkg::STEP_RST; layout_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data[33:32])
          cff_pkg::REG_SEED:   seed_r <= cfg_ch.data[31:0];
          cff_pkg::REG_STEP:   step_r <= cfg_ch.data[31:0];
          cff_pkg::REG_LAYOUT: layout_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      unique case (st_r)
        CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(UNITS - 1)) st_r <= IDLE;
        end
        IDLE: if (in_ch.valid) begin
          fk_r <= in_ch.data[31:0]; ek_r <= in_ch.data[63:32];
          ph_r <= '0; wi_r <= '0; st_r <= HASH;
        end
        HASH: begin
          case (ph_r)
            4'd0: begin
              k_r <= fk_r * 32'h239b961b; h_r <= seed_r; ph_r <= ph_r + 1'b1;
            end
            4'd1: begin
              k_r <= cff_pkg::rotl(k_r, 15) * 32'hab0e9789; ph_r <= ph_r + 1'b1;
            end
            4'd2: begin
              a_r <= (seed_r ^ k_r) ^ 32'd9; b_r <= seed_r ^ 32'd9;
              c_r <= seed_r ^ 32'd9; d_r <= seed_r ^ 32'd9;
              ph_r <= ph_r + 1'b1;
            end
            4'd3: begin a_r <= a_r + b_r + c_r + d_r; ph_r <= ph_r + 1'b1; end
            4'd4: begin
              b_r <= b_r + a_r; c_r <= c_r + a_r; d_r <= d_r + a_r;
              ph_r <= ph_r + 1'b1;
            end
            4'd5: begin a_r <= fmix_a(a_r); b_r <= fmix_a(b_r);
                        c_r <= fmix_a(c_r); d_r <= fmix_a(d_r);
                        ph_r <= ph_r + 1'b1; end
            4'd6: begin a_r <= fmix_b(a_r); b_r <= fmix_b(b_r);
                        c_r <= fmix_b(c_r); d_r <= fmix_b(d_r);
                        ph_r <= ph_r + 1'b1; end
            4'd7: begin a_r <= a_r ^ (a_r >> 16); b_r <= b_r ^ (b_r >> 16);
                        c_r <= c_r ^ (c_r >> 16); d_r <= d_r ^ (d_r >> 16);
                        ph_r <= ph_r + 1'b1; end
            4'd8: begin a_r <= a_r + b_r + c_r + d_r; ph_r <= ph_r + 1'b1; end
            4'd9: begin
              b_r <= b_r + a_r;
              // coupon hash word loop over phases 10, 11 and 13; phase 9 loads the first word
              k_r <= wsel * 32'hcc9e2d51;
              ph_r <= 4'd10;
            end
            4'd10: begin
              k_r <= cff_pkg::rotl(k_r, 15) * 32'h1b873593; ph_r <= 4'd11;
            end
            4'd11: begin
              h_r <= cff_pkg::rotl(h_r ^ k_r, 13) * 32'd5 + 32'he6546b64;
              wi_r <= wi_r + 1'b1;
              if (3'(wi_r) + 3'd1 == wcnt) ph_r <= 4'd12;
              else begin k_r <= '0; ph_r <= 4'd13; end
            end
            4'd13: begin k_r <= wsel * 32'hcc9e2d51; ph_r <= 4'd10; end
            4'd12: begin
              h_r <= fmix_a(h_r ^ {27'd0, wcnt, 2'd0});
              // unit = {b,a} mod UNITS; power of two gives low bits
              unit_r <= AW'({b_r, a_r} % 64'(UNITS));
              ph_r <= 4'd14;
            end
            4'd14: begin
              h_r <= fmix_b(h_r); ph_r <= 4'd15;
            end
            default: begin
              h_r <= h_r ^ (h_r >> 16);
              thr_r <= 36'(step_r); cpn_r <= '0; hit_r <= 1'b0; done_r <= 1'b0;
              st_r <= RD;
            end
          endcase
        end
        RD: begin
          // one coupon compare per cycle; memory read pending on unit_r
          if (!done_r) begin
            if (36'(h_r) < thr_r) begin
              hit_r <= 1'b1; done_r <= 1'b1;
            end else if (32'(cpn_r) == 32'(COUPONS - 1)) begin
              done_r <= 1'b1; cpn_r <= '0;
            end else begin
              cpn_r <= cpn_r + 1'b1; thr_r <= thr_r + 36'(step_r);
            end
          end else st_r <= WB;
        end
        WB: begin
          passed_r <= &newv; st_r <= OUT;
        end
        OUT: if (out_ch.ready) st_r <= IDLE;
        default: st_r <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
